@@ rtl/sha1_pkg.sv @@
// Shared types and constants for the SHA-1 hash engine.
package sha1_pkg;

    typedef logic [31:0] word_t;
    typedef logic [4:0][31:0] chain_t;

    localparam chain_t INIT_CHAIN = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                     32'hEFCDAB89, 32'h67452301};

    localparam logic [1:0] FN_CH   = 2'd0;
    localparam logic [1:0] FN_PAR1 = 2'd1;
    localparam logic [1:0] FN_MAJ  = 2'd2;
    localparam logic [1:0] FN_PAR2 = 2'd3;

    localparam word_t K_CH   = 32'h5A827999;
    localparam word_t K_PAR1 = 32'h6ED9EBA1;
    localparam word_t K_MAJ  = 32'h8F1BBCDC;
    localparam word_t K_PAR2 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef struct packed {
        logic       wr_en;
        logic [5:0] wr_idx;
        logic [7:0] wr_byte;
        logic       shift;
    } sched_ctrl_t;

    typedef struct packed {
        logic       load;
        logic       step;
        logic [1:0] fn;
    } round_ctrl_t;

endpackage

@@ rtl/sha1_sched.sv @@
// Block buffer and message schedule window: byte loading and per-round word expansion.
module sha1_sched (
    input  logic                  aclk,
    input  sha1_pkg::sched_ctrl_t ctrl,
    output sha1_pkg::word_t       w_out
);

    sha1_pkg::word_t win_reg [16];
    sha1_pkg::word_t expand;
    logic [4:0]      lane_base;

    assign lane_base = {~ctrl.wr_idx[1:0], 3'b000};
    assign expand    = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    assign w_out     = win_reg[0];

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            for (int i = 0; i < 15; i++) begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= {expand[30:0], expand[31]};
        end else if (ctrl.wr_en) begin
            win_reg[ctrl.wr_idx[5:2]][lane_base +: 8] <= ctrl.wr_byte;
        end
    end

endmodule

@@ rtl/sha1_round.sv @@
// Shared SHA-1 round unit with the five working registers.
module sha1_round (
    input  logic                  aclk,
    input  sha1_pkg::round_ctrl_t ctrl,
    input  sha1_pkg::chain_t      chain_in,
    input  sha1_pkg::word_t       w_in,
    output sha1_pkg::chain_t      work
);

    sha1_pkg::word_t a_reg, b_reg, c_reg, d_reg, e_reg;
    sha1_pkg::word_t f_val, k_val, temp;

    always_comb begin
        unique case (ctrl.fn)
            sha1_pkg::FN_CH: begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                k_val = sha1_pkg::K_CH;
            end
            sha1_pkg::FN_PAR1: begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = sha1_pkg::K_PAR1;
            end
            sha1_pkg::FN_MAJ: begin
                f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
                k_val = sha1_pkg::K_MAJ;
            end
            default: begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = sha1_pkg::K_PAR2;
            end
        endcase
    end

    assign temp = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_in;
    assign work = {e_reg, d_reg, c_reg, b_reg, a_reg};

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            a_reg <= chain_in[0];
            b_reg <= chain_in[1];
            c_reg <= chain_in[2];
            d_reg <= chain_in[3];
            e_reg <= chain_in[4];
        end else if (ctrl.step) begin
            a_reg <= temp;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

endmodule

@@ rtl/sha1_hash_engine_top.sv @@
// SHA-1 hash engine top level: sequencer, padding, chaining value and digest output.
//
// Input stream: s_tuser is the command (0 absorb, 1 finish), s_tdata the message byte.
// Output stream: five beats per finish, m_tdata a digest word (most significant
// word first), m_tuser its index 0..4, m_tlast high on the fifth word.
// The beat that fills a 64-byte block starts a busy phase: 80 rounds through the
// single shared round unit, then an add of the working words into the chaining value.
// A finish beat feeds padding and length bytes one per cycle through the same
// byte path, pausing for the rounds and add of each full block (one block, or two
// when the pad spills into a second block); then the five digest beats follow.
// s_tready is high only while idle. A stalled receiver holds the digest beat
// in place; nothing is dropped. After the fifth beat the engine returns to the
// initial chaining value with empty counts.
// aresetn (synchronous, active low) loads the initial chaining value and clears
// the byte counts and the sequencer; no clearing pass is needed.
module sha1_hash_engine_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tuser,   // command[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // digest_word[31:0]
    output logic [2:0]  m_tuser,   // word_index[2:0]
    output logic        m_tlast
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROUND = 3'd1;
    localparam logic [2:0] ST_ADD   = 3'd2;
    localparam logic [2:0] ST_PAD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic [1:0] PAD_80   = 2'd0;
    localparam logic [1:0] PAD_FILL = 2'd1;
    localparam logic [1:0] PAD_LEN  = 2'd2;

    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [5:0] LAST_BYTE  = 6'd63;
    localparam logic [5:0] LEN_START  = 6'd56;
    localparam logic [2:0] LAST_WORD  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] cnt_reg, cnt_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic        fin_reg, fin_next;
    logic [1:0]  pad_reg, pad_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    sha1_pkg::chain_t chain_reg, chain_next;

    sha1_pkg::sched_ctrl_t sched_ctrl;
    sha1_pkg::round_ctrl_t round_ctrl;
    sha1_pkg::word_t       w_word;
    sha1_pkg::chain_t      work;

    logic        put_en;
    logic [7:0]  put_byte;
    logic [63:0] len_bits;
    logic [7:0]  len_byte;
    logic [5:0]  len_base;

    assign len_bits = {cnt_reg, 3'b000};
    assign len_base = {~fill_reg[2:0], 3'b000};
    assign len_byte = len_bits[len_base +: 8];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = chain_reg[0];
    assign m_tuser  = out_idx_reg;
    assign m_tlast  = (out_idx_reg == LAST_WORD);

    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        cnt_next     = cnt_reg;
        rnd_next     = rnd_reg;
        fin_next     = fin_reg;
        pad_next     = pad_reg;
        out_idx_next = out_idx_reg;
        chain_next   = chain_reg;
        put_en       = 1'b0;
        put_byte     = s_tdata;
        round_ctrl.load = 1'b0;
        round_ctrl.step = 1'b0;

        if (rnd_reg < 7'd20) begin
            round_ctrl.fn = sha1_pkg::FN_CH;
        end else if (rnd_reg < 7'd40) begin
            round_ctrl.fn = sha1_pkg::FN_PAR1;
        end else if (rnd_reg < 7'd60) begin
            round_ctrl.fn = sha1_pkg::FN_MAJ;
        end else begin
            round_ctrl.fn = sha1_pkg::FN_PAR2;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == sha1_pkg::CMD_ABSORB) begin
                        put_en   = 1'b1;
                        cnt_next = cnt_reg + 61'd1;
                    end else begin
                        fin_next   = 1'b1;
                        pad_next   = PAD_80;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                put_en = 1'b1;
                unique case (pad_reg)
                    PAD_80: begin
                        put_byte = sha1_pkg::PAD_BYTE;
                        pad_next = PAD_FILL;
                    end
                    PAD_FILL: begin
                        if (fill_reg == LEN_START) begin
                            put_byte = len_byte;
                            pad_next = PAD_LEN;
                        end else begin
                            put_byte = 8'h00;
                        end
                    end
                    default: begin
                        put_byte = len_byte;
                    end
                endcase
            end
            ST_ROUND: begin
                round_ctrl.step = 1'b1;
                if (rnd_reg == LAST_ROUND) begin
                    rnd_next   = '0;
                    state_next = ST_ADD;
                end else begin
                    rnd_next = rnd_reg + 7'd1;
                end
            end
            ST_ADD: begin
                for (int i = 0; i < 5; i++) begin
                    chain_next[i] = chain_reg[i] + work[i];
                end
                if (!fin_reg) begin
                    state_next = ST_IDLE;
                end else if (pad_reg == PAD_LEN) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_PAD;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    chain_next = sha1_pkg::chain_t'({32'd0, chain_reg[4:1]});
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == LAST_WORD) begin
                        chain_next   = sha1_pkg::INIT_CHAIN;
                        out_idx_next = '0;
                        fill_next    = '0;
                        cnt_next     = '0;
                        fin_next     = 1'b0;
                        pad_next     = PAD_80;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (put_en) begin
            fill_next = fill_reg + 6'd1;
            if (fill_reg == LAST_BYTE) begin
                round_ctrl.load = 1'b1;
                state_next      = ST_ROUND;
            end
        end
    end

    assign sched_ctrl.wr_en   = put_en;
    assign sched_ctrl.wr_idx  = fill_reg;
    assign sched_ctrl.wr_byte = put_byte;
    assign sched_ctrl.shift   = round_ctrl.step;

    sha1_sched u_sched (
        .aclk  (aclk),
        .ctrl  (sched_ctrl),
        .w_out (w_word)
    );

    sha1_round u_round (
        .aclk     (aclk),
        .ctrl     (round_ctrl),
        .chain_in (chain_reg),
        .w_in     (w_word),
        .work     (work)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            cnt_reg     <= '0;
            rnd_reg     <= '0;
            fin_reg     <= 1'b0;
            pad_reg     <= PAD_80;
            out_idx_reg <= '0;
            chain_reg   <= sha1_pkg::INIT_CHAIN;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            cnt_reg     <= cnt_next;
            rnd_reg     <= rnd_next;
            fin_reg     <= fin_next;
            pad_reg     <= pad_next;
            out_idx_reg <= out_idx_next;
            chain_reg   <= chain_next;
        end
    end

endmodule
